/* src/hsv_to_rgb_converter_core_macros.svh */
// Assertion macros for the HSV to RGB converter.
// Used by the top level; expect clk_i and rst_ni in scope.
`ifndef HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define HSVRGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsvrgb: check failed");

// Same, with a caller-supplied message.
`define HSVRGB_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

/* src/hsvrgb_pkg.sv */
// Shared constants, types and stage records of the HSV to RGB converter.
// No dependencies.
package hsvrgb_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned CHANNEL_BITS = 8;

  localparam int unsigned IN_W   = FRAC_BITS + 1;      // Q1.F input
  localparam int unsigned H6_W   = IN_W + 3;           // 6*hue
  localparam int unsigned SEC_W  = 3;
  localparam int unsigned PROD_W = 2 * FRAC_BITS + 1;  // Q1.2F, max 1.0
  localparam int unsigned LO_W   = FRAC_BITS + IN_W;   // low chroma * f
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned RND_SHIFT = 2 * FRAC_BITS - CHANNEL_BITS;
  localparam int unsigned RND_W  = SUM_W - RND_SHIFT;

  localparam logic [IN_W-1:0]         ONE_Q    = IN_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0]        RND_HALF = SUM_W'(1) << (RND_SHIFT - 1);
  localparam logic [CHANNEL_BITS-1:0] CH_MAX   = {CHANNEL_BITS{1'b1}};

  // Hue sector, floor(6*hue); hue of exactly 1.0 lands in SEC_WRAP.
  typedef enum logic [SEC_W-1:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5,
    SEC_WRAP          = 3'd6
  } sector_e;

  typedef struct packed {
    logic [PROD_W-1:0] chroma;
    logic [IN_W-1:0]   value;
    logic [IN_W-1:0]   frac;    // 1 - |(6h mod 2) - 1|
    sector_e           sector;
  } prep_t;

  typedef struct packed {
    logic [PROD_W-1:0] chroma;
    logic [PROD_W-1:0] x_part;  // X
    logic [PROD_W-1:0] offset;  // m = V - C
    sector_e           sector;
  } mix_t;

endpackage

/* src/hsvrgb_prep.sv */
// Stage 1: input clamp, hue sector and ramp, chroma multiply.
// Depends on hsvrgb_pkg.
module hsvrgb_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [hsvrgb_pkg::IN_W-1:0] hue_i,
  input  logic [hsvrgb_pkg::IN_W-1:0] saturation_i,
  input  logic [hsvrgb_pkg::IN_W-1:0] brightness_i,
  output logic                        valid_o,
  output hsvrgb_pkg::prep_t           prep_o
);
  import hsvrgb_pkg::*;

  logic [IN_W-1:0]   hue, sat, val;
  logic [H6_W-1:0]   hue6;
  logic [IN_W-1:0]   ramp;
  logic [2*IN_W-1:0] chroma_full;
  prep_t             prep_d, prep_q;
  logic              valid_q;

  always_comb begin
    hue = (hue_i > ONE_Q) ? ONE_Q : hue_i;
    sat = (saturation_i > ONE_Q) ? ONE_Q : saturation_i;
    val = (brightness_i > ONE_Q) ? ONE_Q : brightness_i;

    hue6 = {2'b00, hue, 1'b0} + {1'b0, hue, 2'b00};
    // odd half of a sector pair ramps down
    ramp = hue6[FRAC_BITS] ? (ONE_Q - {1'b0, hue6[FRAC_BITS-1:0]}) : hue6[FRAC_BITS:0];

    chroma_full = sat * val;

    prep_d.chroma = chroma_full[PROD_W-1:0];
    prep_d.value  = val;
    prep_d.frac   = ramp;
    prep_d.sector = sector_e'(hue6[FRAC_BITS+SEC_W-1:FRAC_BITS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

/* src/hsvrgb_mix.sv */
// Stages 2 and 3: offset m, split X multiply, X sum.
// Depends on hsvrgb_pkg.
module hsvrgb_mix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hsvrgb_pkg::prep_t prep_i,
  output logic              valid_o,
  output hsvrgb_pkg::mix_t  mix_o
);
  import hsvrgb_pkg::*;

  logic [2*IN_W-1:0] hi_full;
  logic [PROD_W-1:0] hi_d, hi_q;
  logic [LO_W-1:0]   lo_d, lo_q;
  logic [PROD_W-1:0] chroma_q, offset_d, offset_q;
  sector_e           sector_q;
  logic              valid2_q, valid3_q;
  mix_t              mix_d, mix_q;

  // X = chroma_hi*f + (chroma_lo*f >> F), exact floor of chroma*f/ONE
  always_comb begin
    hi_full  = prep_i.chroma[PROD_W-1:FRAC_BITS] * prep_i.frac;
    hi_d     = hi_full[PROD_W-1:0];
    lo_d     = prep_i.chroma[FRAC_BITS-1:0] * prep_i.frac;
    offset_d = {prep_i.value, {FRAC_BITS{1'b0}}} - prep_i.chroma;
  end

  always_comb begin
    mix_d.chroma = chroma_q;
    mix_d.x_part = hi_q + PROD_W'(lo_q >> FRAC_BITS);
    mix_d.offset = offset_q;
    mix_d.sector = sector_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid2_q <= valid_i;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    chroma_q <= prep_i.chroma;
    offset_q <= offset_d;
    sector_q <= prep_i.sector;
    mix_q    <= mix_d;
  end

  assign valid_o = valid3_q;
  assign mix_o   = mix_q;

endmodule

/* src/hsvrgb_out.sv */
// Stage 4: sector ordering, offset add, rounding and saturation.
// Depends on hsvrgb_pkg.
module hsvrgb_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  hsvrgb_pkg::mix_t                    mix_i,
  output logic                                valid_o,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0] red_o,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0] green_o,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0] blue_o
);
  import hsvrgb_pkg::*;

  localparam logic [RND_W-1:0] CH_MAX_R = RND_W'(CH_MAX);

  logic [PROD_W-1:0]       r_sel, g_sel, b_sel;
  logic [CHANNEL_BITS-1:0] red_d, green_d, blue_d;
  logic [CHANNEL_BITS-1:0] red_q, green_q, blue_q;
  logic                    valid_q;

  function automatic logic [CHANNEL_BITS-1:0] to_channel(
    input logic [PROD_W-1:0] part,
    input logic [PROD_W-1:0] offset
  );
    logic [SUM_W-1:0] sum;
    logic [RND_W-1:0] rnd;
    sum = SUM_W'(part) + SUM_W'(offset) + RND_HALF;
    rnd = sum[SUM_W-1:RND_SHIFT];
    return (rnd > CH_MAX_R) ? CH_MAX : rnd[CHANNEL_BITS-1:0];
  endfunction

  always_comb begin
    r_sel = '0;
    g_sel = '0;
    b_sel = '0;
    unique case (mix_i.sector)
      SEC_RED_YELLOW: begin
        r_sel = mix_i.chroma; g_sel = mix_i.x_part;
      end
      SEC_YELLOW_GREEN: begin
        r_sel = mix_i.x_part; g_sel = mix_i.chroma;
      end
      SEC_GREEN_CYAN: begin
        g_sel = mix_i.chroma; b_sel = mix_i.x_part;
      end
      SEC_CYAN_BLUE: begin
        g_sel = mix_i.x_part; b_sel = mix_i.chroma;
      end
      SEC_BLUE_MAGENTA: begin
        r_sel = mix_i.x_part; b_sel = mix_i.chroma;
      end
      default: begin
        r_sel = mix_i.chroma; b_sel = mix_i.x_part;
      end
    endcase
    red_d   = to_channel(r_sel, mix_i.offset);
    green_d = to_channel(g_sel, mix_i.offset);
    blue_d  = to_channel(b_sel, mix_i.offset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

/* src/hsv_to_rgb_converter_core.sv */
// HSV to RGB converter top level: four-stage pipeline, one pixel item per cycle while busy is low.
// A result strobes on valid_o once its item has passed the prep, mix and out registers.
// Stages: clamp+chroma multiply, offset+split X multiply, X sum, ordering+round+saturate.
// The receiver cannot stall; busy is low from the first clock after reset and stays low.
// Async active-low reset clears the valid bits and ready only, so nothing in flight is delivered.
// Depends on hsvrgb_pkg, hsvrgb_prep, hsvrgb_mix, hsvrgb_out and the macros header.
`include "hsv_to_rgb_converter_core_macros.svh"

module hsv_to_rgb_converter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [hsvrgb_pkg::IN_W-1:0]         hue_i,
  input  logic [hsvrgb_pkg::IN_W-1:0]         saturation_i,
  input  logic [hsvrgb_pkg::IN_W-1:0]         brightness_i,
  output logic                                valid_o,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0] red_o,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0] green_o,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0] blue_o
);
  import hsvrgb_pkg::*;

  // ready rises on the clock after reset release and never drops
  logic  ready_q;
  logic  accept;

  logic  prep_valid;
  prep_t prep;
  logic  mix_valid;
  mix_t  mix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= 1'b1;
    end
  end

  assign busy   = ~ready_q;
  assign accept = start & ready_q;

  // Stage 1: clamp to 1.0, sector and ramp from 6*hue, C = S*V
  hsvrgb_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (prep_valid),
    .prep_o       (prep)
  );

  // Stages 2 and 3: m = V - C, X built from two narrow products
  hsvrgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .valid_o (mix_valid),
    .mix_o   (mix)
  );

  // Stage 4: place C and X by sector, add m, round half up, clip to full scale
  hsvrgb_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .mix_i   (mix),
    .valid_o (valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  // every item taken gives its result on valid_o after passing the prep, mix and out registers
  `HSVRGB_ASSERT(a_latency, accept |-> ##4 valid_o)
  // grey: no saturation means C and X vanish, all channels equal m
  `HSVRGB_ASSERT_MSG(a_grey, (accept && saturation_i == '0) |-> ##4 (red_o == green_o && green_o == blue_o), "hsvrgb: grey item not grey")
  // black: zero brightness gives zero on every channel
  `HSVRGB_ASSERT_MSG(a_black, (accept && brightness_i == '0) |-> ##4 (red_o == '0 && green_o == '0 && blue_o == '0), "hsvrgb: dark item not black")
  // once ready, the pipeline never pushes back
  `HSVRGB_ASSERT(a_no_stall, !busy |=> !busy)

endmodule
